// ===== hw/rtl/ptm2m_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm2m_pkg
// Codes, entry bits and helpers shared by the 2 MiB page table mapper.
// ----------------------------------------------------------------------------
package ptm2m_pkg;

  localparam int unsigned IDX_W = 9;   // index bits per table level
  localparam int unsigned PAGE_W = 40; // 4 KiB page number width

  // request actions
  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // result status
  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLE   = 2'd1;
  localparam logic [1:0] STATUS_POOL_EMPTY = 2'd2;

  // flag selects
  localparam logic [1:0] FSEL_WRITABLE = 2'd0;
  localparam logic [1:0] FSEL_ACCESSED = 2'd1;
  localparam logic [1:0] FSEL_DIRTY    = 2'd2;

  // entry bits
  localparam logic [63:0] BIT_LARGE    = 64'h80;
  localparam logic [63:0] BIT_DIRTY    = 64'h40;
  localparam logic [63:0] BIT_ACCESSED = 64'h20;
  localparam logic [63:0] BIT_WRITABLE = 64'h02;
  localparam logic [63:0] BIT_PRESENT  = 64'h01;

  typedef logic [63:0] entry_t;

  function automatic entry_t flag_mask(input logic [1:0] sel);
    entry_t m;
    unique case (sel)
      FSEL_WRITABLE: m = BIT_WRITABLE;
      FSEL_ACCESSED: m = BIT_ACCESSED;
      FSEL_DIRTY:    m = BIT_DIRTY;
      default:       m = '0;
    endcase
    return m;
  endfunction

  // Directory entry for a 2 MiB frame: large, writable, present.
  function automatic entry_t large_entry(input logic [30:0] frame);
    return {12'd0, frame, 21'd0} | BIT_LARGE | BIT_WRITABLE | BIT_PRESENT;
  endfunction

  // Link entry pointing at a physical page: writable, present.
  function automatic entry_t link_entry(input logic [PAGE_W-1:0] page);
    return {12'd0, page, 12'd0} | BIT_WRITABLE | BIT_PRESENT;
  endfunction

endpackage

// ===== hw/rtl/page_table_mapper_2m.sv =====
// ----------------------------------------------------------------------------
// page_table_mapper_2m
// Three-level walk over a store of 512-entry page tables, mapping 2 MiB pages.
// ----------------------------------------------------------------------------
// Sequence: check the root and read the top entry, read the pointer entry, read
//   the dir entry and write it back (clear, set) or only read it (query); map
//   writes any new top and pointer links, then the mapped dir entry. A failing
//   request stops at the step that fails. One request is walked at a time, and a
//   held result stalls the next request. Reset: control clears at once, then a
//   clearing pass zeroes the store (no requests).
module page_table_mapper_2m
  import ptm2m_pkg::*;
#(
  parameter int unsigned TABLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [5:0]  root_table,
  input  logic [47:0] virt_addr,
  input  logic [30:0] frame_number,
  input  logic [1:0]  flag_select,
  input  logic        flag_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        flag_bit,
  output logic [63:0] entry_value,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned TIW   = (TABLES > 1) ? $clog2(TABLES) : 1; // table index
  localparam int unsigned AW    = TIW + IDX_W;                        // store address
  localparam int unsigned DEPTH = TABLES * (1 << IDX_W);
  localparam int unsigned NFW   = (TIW + 1 > 7) ? TIW + 1 : 7;        // free counter

  // walk sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1; // check root, read top entry
  localparam logic [3:0] S_TOP  = 4'd2; // top entry back, read pointer entry
  localparam logic [3:0] S_PDP  = 4'd3; // pointer entry back, read dir entry
  localparam logic [3:0] S_ENT  = 4'd4; // dir entry back, modify and write
  localparam logic [3:0] S_WTOP = 4'd5; // write new top link
  localparam logic [3:0] S_WPDP = 4'd6; // write new pointer link
  localparam logic [3:0] S_WENT = 4'd7; // write mapped dir entry
  localparam logic [3:0] S_DONE = 4'd8; // hand result to output register

  logic [3:0] state;

  // registers
  logic [PAGE_W-1:0] pool_base;
  logic [6:0]        first_free;
  logic [NFW-1:0]    next_free;

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // latched request
  logic [1:0]       req_action;
  logic [5:0]       req_root;
  logic [IDX_W-1:0] req_i4, req_i3, req_i2;
  logic [30:0]      req_frame;
  logic [1:0]       req_fsel;
  logic             req_fval;

  logic [TIW-1:0] pdp_tbl, pd_tbl;
  logic [1:0]     alloc_need;

  // pending result
  logic [1:0] res_status;
  logic       res_flag;
  entry_t     res_entry;

  // table store
  entry_t        mem [DEPTH];
  entry_t        mem_rdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  entry_t        mem_wdata;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // registers sit 8 bytes apart; paddr[3] picks one
  assign prdata = paddr[3] ? {57'd0, first_free} : {24'd0, pool_base};

  // ---------------------------------------------------------------------------
  // Link decode of the entry just read: present and pointing inside the pool
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0] lk_off;
  logic              lk_ok;
  logic [TIW-1:0]    lk_tbl;
  assign lk_off = mem_rdata[51:12] - pool_base;
  assign lk_ok  = mem_rdata[0] && (lk_off < PAGE_W'(TABLES));
  assign lk_tbl = lk_off[TIW-1:0];

  // pool check: would allocating pool_need tables run past the store
  logic [1:0]     pool_need;
  logic           pool_short;
  assign pool_need  = (state == S_TOP) ? 2'd2 : 2'd1;
  assign pool_short = ({1'b0, next_free} + (NFW+1)'(pool_need)) > (NFW+1)'(TABLES);

  logic   bad_root;
  entry_t fmask;
  entry_t ent_new;
  assign bad_root = 32'(req_root) >= TABLES;
  assign fmask    = flag_mask(req_fsel);

  always_comb begin
    unique case (req_action)
      ACT_CLEAR: ent_new = '0;
      ACT_SET:   ent_new = req_fval ? (mem_rdata | fmask) : (mem_rdata & ~fmask);
      default:   ent_new = mem_rdata;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory port: one access a cycle, chosen by the clearing pass or the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_addr  = clr_addr;
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (clearing) begin
      mem_we = 1'b1;
    end else begin
      unique case (state)
        S_ROOT: mem_addr = {TIW'(req_root), req_i4};
        S_TOP:  mem_addr = {lk_tbl, req_i3};
        S_PDP:  mem_addr = {lk_tbl, req_i2};
        S_ENT: begin
          mem_addr  = {pd_tbl, req_i2};
          mem_we    = (req_action == ACT_CLEAR) || (req_action == ACT_SET);
          mem_wdata = ent_new;
        end
        S_WTOP: begin
          mem_addr  = {TIW'(req_root), req_i4};
          mem_we    = 1'b1;
          mem_wdata = link_entry(pool_base + PAGE_W'(pdp_tbl));
        end
        S_WPDP: begin
          mem_addr  = {pdp_tbl, req_i3};
          mem_we    = 1'b1;
          mem_wdata = link_entry(pool_base + PAGE_W'(pd_tbl));
        end
        S_WENT: begin
          mem_addr  = {pd_tbl, req_i2};
          mem_we    = 1'b1;
          mem_wdata = large_entry(req_frame);
        end
        default: mem_addr = clr_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Clearing pass and registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      first_free <= 7'd1;
      next_free  <= NFW'(1);
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        first_free <= pwdata[6:0];
        next_free  <= NFW'(pwdata[6:0]);
      end else begin
        pool_base <= pwdata[PAGE_W-1:0];
      end
    end else if (state == S_WENT) begin
      next_free <= next_free + NFW'(alloc_need);
    end
  end

  // ---------------------------------------------------------------------------
  // Walk sequencer
  // ---------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: state <= bad_root ? S_DONE : S_TOP;
        S_TOP: begin
          if (lk_ok) begin
            state <= S_PDP;
          end else if (req_action != ACT_MAP || mem_rdata[0] || pool_short) begin
            state <= S_DONE;
          end else begin
            state <= S_WTOP;
          end
        end
        S_PDP: begin
          if (lk_ok) begin
            state <= (req_action == ACT_MAP) ? S_WENT : S_ENT;
          end else if (req_action != ACT_MAP || mem_rdata[0] || pool_short) begin
            state <= S_DONE;
          end else begin
            state <= S_WPDP;
          end
        end
        S_ENT:  state <= S_DONE;
        S_WTOP: state <= S_WPDP;
        S_WPDP: state <= S_WENT;
        S_WENT: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request payload and walk results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) begin
      req_action <= action;
      req_root   <= root_table;
      req_i4     <= virt_addr[47:39];
      req_i3     <= virt_addr[38:30];
      req_i2     <= virt_addr[29:21];
      req_frame  <= frame_number;
      req_fsel   <= flag_select;
      req_fval   <= flag_value;
      alloc_need <= 2'd0;
    end
    unique case (state)
      S_ROOT: begin
        res_status <= STATUS_NO_TABLE;
        res_flag   <= 1'b0;
        res_entry  <= '0;
      end
      S_TOP: begin
        if (lk_ok) begin
          pdp_tbl <= lk_tbl;
        end else if (req_action == ACT_MAP && !mem_rdata[0] && pool_short) begin
          res_status <= STATUS_POOL_EMPTY;
        end else begin
          // both tables come from the pool, pointer level first
          pdp_tbl    <= next_free[TIW-1:0];
          pd_tbl     <= TIW'(next_free + NFW'(1));
          alloc_need <= 2'd2;
        end
      end
      S_PDP: begin
        if (lk_ok) begin
          pd_tbl <= lk_tbl;
        end else if (req_action == ACT_MAP && !mem_rdata[0] && pool_short) begin
          res_status <= STATUS_POOL_EMPTY;
        end else begin
          pd_tbl     <= next_free[TIW-1:0];
          alloc_need <= 2'd1;
        end
      end
      S_ENT: begin
        res_status <= STATUS_DONE;
        res_flag   <= |(ent_new & fmask);
        res_entry  <= ent_new;
      end
      S_WENT: begin
        res_status <= STATUS_DONE;
        res_flag   <= |(large_entry(req_frame) & fmask);
        res_entry  <= large_entry(req_frame);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      flag_bit    <= res_flag;
      entry_value <= res_entry;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // allocation never runs the free counter past the store
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WENT) |->
      (({1'b0, next_free} + (NFW+1)'(alloc_need)) <= (NFW+1)'(TABLES)))
    else $error("table allocation past end of pool");

  // only map can report an empty pool
  a_pool_map: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == STATUS_POOL_EMPTY) |-> (req_action == ACT_MAP))
    else $error("pool status on a non-map request");

  // a failed request leaves the store untouched
  a_fail_nowrite: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |->
      (state == S_ENT || state == S_WTOP || state == S_WPDP || state == S_WENT))
    else $error("store write outside a write-back step");

  // a finished walk reaches the output in the next cycle when it is free
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

endmodule

// ===== verif/tb_page_table_mapper_2m.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_table_mapper_2m
// Self-checking bench for the 2 MiB page table mapper. It keeps a shadow
// table store that walks every request the way the block should, and checks
// each result field by field, in order. Directed walks and pool/decode corner
// cases come first, then random traffic in phases with changing pool settings,
// random idle gaps on both channels and one long result back-pressure window.
// ----------------------------------------------------------------------------
module tb_page_table_mapper_2m;
  import ptm2m_pkg::*;

  localparam int unsigned NUM_TABLES     = 64;
  localparam int unsigned TABLE_ENTRIES  = 512;
  localparam int unsigned HOLD_CYCLES    = 200;     // long result back-pressure
  localparam int unsigned WATCHDOG_LIMIT = 100000;  // covers the clearing pass
  localparam int unsigned MAX_PRINTS     = 100;

  // register map: 64-bit data, so registers sit on 8-byte strides
  localparam logic [3:0] REG_POOL_BASE  = 4'h0;
  localparam logic [3:0] REG_FIRST_FREE = 4'h8;

  // flag select code that names no bit
  localparam logic [1:0] FSEL_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  root;
    logic [47:0] va;
    logic [30:0] frame;
    logic [1:0]  fsel;
    logic        fval;
  } map_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        flag;
    logic [63:0] entry;
  } map_rsp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [5:0]  root_table;
  logic [47:0] virt_addr;
  logic [30:0] frame_number;
  logic [1:0]  flag_select;
  logic        flag_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        flag_bit;
  logic [63:0] entry_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // shadow state of the block
  logic [63:0] shadow_store [0:NUM_TABLES*TABLE_ENTRIES-1];
  logic [39:0] shadow_pool_base;
  int unsigned shadow_next_free;

  map_rsp_t    expected_q[$];
  int unsigned error_count;
  int unsigned result_seq;
  int unsigned idle_cycles;

  // knobs shared between the stimulus and the result sink
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  bit          hold_req;
  logic [8:0]  hot_top;   // top-level index that random traffic clusters around

  page_table_mapper_2m #(
    .TABLES(NUM_TABLES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .root_table  (root_table),
    .virt_addr   (virt_addr),
    .frame_number(frame_number),
    .flag_select (flag_select),
    .flag_value  (flag_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .flag_bit    (flag_bit),
    .entry_value (entry_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow walk
  // --------------------------------------------------------------------------

  // Physical address of pool table t; page number wraps at 40 bits.
  function automatic logic [63:0] table_phys(input int unsigned t);
    logic [39:0] page;
    page = shadow_pool_base + 40'(t);
    return {12'd0, page, 12'd0};
  endfunction

  // A link is usable only if present and its page lands inside the store.
  function automatic bit follow_link(input logic [63:0] e, output int unsigned t);
    logic [39:0] idx;
    t = 0;
    if ((e & BIT_PRESENT) == 64'd0) return 1'b0;
    idx = e[51:12] - shadow_pool_base;
    if (idx >= 40'(NUM_TABLES)) return 1'b0;
    t = int'(idx);
    return 1'b1;
  endfunction

  function automatic logic [63:0] select_mask(input logic [1:0] sel);
    case (sel)
      FSEL_WRITABLE: return BIT_WRITABLE;
      FSEL_ACCESSED: return BIT_ACCESSED;
      FSEL_DIRTY:    return BIT_DIRTY;
      default:       return 64'd0;
    endcase
  endfunction

  // Applies one request to the shadow store and returns the result it gives.
  function automatic map_rsp_t walk_request(input map_req_t r);
    map_rsp_t    rsp;
    int unsigned top_at, mid_at, leaf_at;
    int unsigned pdp, pd, need;
    logic [63:0] top_e, mid_e, fm;
    bit          have_pdp, have_pd;
    logic [1:0]  st;
    rsp = '0;
    pdp = 0;
    pd  = 0;
    if (int'(r.root) >= NUM_TABLES) begin
      rsp.status = STATUS_NO_TABLE;
      return rsp;
    end
    fm     = select_mask(r.fsel);
    top_at = {r.root, r.va[47:39]};
    top_e  = shadow_store[top_at];
    st     = STATUS_DONE;

    if (r.action == ACT_MAP) begin
      have_pdp = follow_link(top_e, pdp);
      have_pd  = 1'b0;
      need     = 0;
      if (!have_pdp && (top_e & BIT_PRESENT) != 64'd0) begin
        st = STATUS_NO_TABLE;      // present but points outside the store
      end else if (have_pdp) begin
        mid_e   = shadow_store[pdp * TABLE_ENTRIES + r.va[38:30]];
        have_pd = follow_link(mid_e, pd);
        if (!have_pd && (mid_e & BIT_PRESENT) != 64'd0) st = STATUS_NO_TABLE;
        if (!have_pd) need = 1;
      end else begin
        need = 2;
      end
      // pool is checked before anything is written
      if (st == STATUS_DONE && need > 0 && shadow_next_free + need > NUM_TABLES)
        st = STATUS_POOL_EMPTY;
      if (st != STATUS_DONE) begin
        rsp.status = st;
        return rsp;
      end
      // new tables are taken as they are, stale contents included
      if (!have_pdp) begin
        pdp = shadow_next_free;
        shadow_next_free++;
        shadow_store[top_at] = table_phys(pdp) | BIT_WRITABLE | BIT_PRESENT;
      end
      if (!have_pd) begin
        pd = shadow_next_free;
        shadow_next_free++;
        mid_at = pdp * TABLE_ENTRIES + r.va[38:30];
        shadow_store[mid_at] = table_phys(pd) | BIT_WRITABLE | BIT_PRESENT;
      end
      leaf_at = pd * TABLE_ENTRIES + r.va[29:21];
      shadow_store[leaf_at] = {12'd0, r.frame, 21'd0} | BIT_LARGE | BIT_WRITABLE
                              | BIT_PRESENT;
    end else begin
      // clear, set and query need both intermediate links in place
      if (!follow_link(top_e, pdp) ||
          !follow_link(shadow_store[pdp * TABLE_ENTRIES + r.va[38:30]], pd)) begin
        rsp.status = STATUS_NO_TABLE;
        return rsp;
      end
      leaf_at = pd * TABLE_ENTRIES + r.va[29:21];
      if (r.action == ACT_CLEAR)
        shadow_store[leaf_at] = 64'd0;
      else if (r.action == ACT_SET)
        shadow_store[leaf_at] = r.fval ? (shadow_store[leaf_at] | fm)
                                       : (shadow_store[leaf_at] & ~fm);
    end
    rsp.status = STATUS_DONE;
    rsp.flag   = (shadow_store[leaf_at] & fm) != 64'd0;
    rsp.entry  = shadow_store[leaf_at];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offers one request; valid stays up across back-to-back requests.
  task automatic send_request(input map_req_t r);
    int unsigned pause;
    pause = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= r.action;
    root_table   <= r.root;
    virt_addr    <= r.va;
    frame_number <= r.frame;
    flag_select  <= r.fsel;
    flag_value   <= r.fval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(walk_request(r));
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [5:0] root,
                             input logic [47:0] va, input logic [30:0] frame,
                             input logic [1:0] fsel, input logic fval);
    map_req_t r;
    r = {act, root, va, frame, fsel, fval};
    send_request(r);
  endtask

  // Drops valid and waits until every outstanding request has answered.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == REG_POOL_BASE) begin
      shadow_pool_base = data[39:0];
    end else if (addr == REG_FIRST_FREE) begin
      shadow_next_free = int'(data[6:0]);   // reloads the bump pointer too
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Only ever called with the block idle.
  task automatic set_config(input logic [39:0] base, input logic [6:0] first);
    drain_requests();
    reg_write(REG_POOL_BASE, {24'd0, base});
    reg_write(REG_FIRST_FREE, {57'd0, first});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [47:0] walk_addr(input logic [8:0] i4, input logic [8:0] i3,
                                            input logic [8:0] i2);
    logic [31:0] w;
    w = $urandom;
    return {i4, i3, i2, w[20:0]};
  endfunction

  // Mostly near a hot index so walks share tables; some extremes and noise.
  function automatic logic [8:0] pick_index(input logic [8:0] hot, input int unsigned spread);
    int unsigned roll;
    logic [31:0] w;
    roll = $urandom_range(0, 99);
    w    = $urandom;
    if (roll < 75) return hot + 9'($urandom_range(0, spread - 1));
    if (roll < 85) return 9'h1FF;
    return w[8:0];
  endfunction

  function automatic map_req_t random_request();
    map_req_t    r;
    logic [63:0] w, w2;
    int unsigned roll;
    w    = {$urandom, $urandom};
    w2   = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: every field uniform
      r = {w[1:0], w[7:2], w2[47:0], w[38:8], w[40:39], w[41]};
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 35)      r.action = ACT_MAP;
    else if (roll < 45) r.action = ACT_CLEAR;
    else if (roll < 75) r.action = ACT_SET;
    else                r.action = ACT_QUERY;
    r.root  = ($urandom_range(0, 9) == 0) ? w[7:2] : {4'd0, w[9:8]};
    r.va    = {pick_index(hot_top, 2), pick_index(9'd0, 4), pick_index(9'd0, 4),
               w2[20:0]};
    r.frame = w[40:10];
    case ($urandom_range(0, 9))
      0:       r.fsel = FSEL_NONE;
      1, 2, 3: r.fsel = FSEL_WRITABLE;
      4, 5, 6: r.fsel = FSEL_ACCESSED;
      default: r.fsel = FSEL_DIRTY;
    endcase
    r.fval = w[41];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-built walks: missing links, allocation of two, one and no tables,
  // remap, every flag select both ways, clear and set on a cleared entry.
  task automatic test_directed_walks();
    logic [47:0] va0;
    int unsigned sel;
    va0 = walk_addr(9'd0, 9'd0, 9'd0);
    send_fields(ACT_QUERY, 6'd0, va0, 31'd0, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_CLEAR, 6'd0, 48'hFFFF_FFFF_FFFF, 31'd0, FSEL_DIRTY, 1'b0);
    send_fields(ACT_SET, 6'd0, va0, 31'd0, FSEL_DIRTY, 1'b1);
    send_fields(ACT_MAP, 6'd0, va0, 31'd0, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_MAP, 6'd63, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, FSEL_NONE, 1'b1);
    send_fields(ACT_MAP, 6'd0, walk_addr(9'd0, 9'd1, 9'd0), 31'h2AAA_5555, FSEL_DIRTY,
                1'b0);
    send_fields(ACT_MAP, 6'd0, walk_addr(9'd0, 9'd0, 9'h1FF), 31'h5555_2AAA,
                FSEL_ACCESSED, 1'b1);
    send_fields(ACT_MAP, 6'd0, va0, 31'h1234_5678, FSEL_WRITABLE, 1'b0);
    for (sel = 0; sel < 4; sel++)
      send_fields(ACT_SET, 6'd0, walk_addr(9'd0, 9'd0, 9'd0), 31'd0, 2'(sel), 1'b1);
    for (sel = 0; sel < 4; sel++)
      send_fields(ACT_QUERY, 6'd0, walk_addr(9'd0, 9'd0, 9'd0), 31'd0, 2'(sel), 1'b0);
    for (sel = 0; sel < 3; sel++)
      send_fields(ACT_SET, 6'd0, walk_addr(9'd0, 9'd0, 9'd0), 31'd0, 2'(sel), 1'b0);
    send_fields(ACT_QUERY, 6'd0, va0, 31'd0, FSEL_ACCESSED, 1'b0);
    send_fields(ACT_CLEAR, 6'd0, va0, 31'd0, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_QUERY, 6'd0, va0, 31'd0, FSEL_WRITABLE, 1'b1);
    send_fields(ACT_SET, 6'd0, va0, 31'd0, FSEL_DIRTY, 1'b1);
    send_fields(ACT_CLEAR, 6'd63, 48'hFFFF_FFFF_FFFF, 31'd0, FSEL_WRITABLE, 1'b0);
  endtask

  // Pool exhaustion at both allocation depths, last table, and a pool that
  // starts at table 0 so a root gets handed out as a walk table.
  task automatic test_pool_limits();
    set_config(40'd0, 7'd64);
    send_fields(ACT_MAP, 6'd1, walk_addr(9'd3, 9'd3, 9'd3), 31'd1, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_MAP, 6'd0, walk_addr(9'd0, 9'd0, 9'd7), 31'd2, FSEL_WRITABLE, 1'b0);
    set_config(40'd0, 7'd63);
    send_fields(ACT_MAP, 6'd1, walk_addr(9'd4, 9'd4, 9'd4), 31'd3, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_MAP, 6'd0, walk_addr(9'd0, 9'd2, 9'd0), 31'd4, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_MAP, 6'd0, walk_addr(9'd0, 9'd3, 9'd0), 31'd5, FSEL_WRITABLE, 1'b0);
    set_config(40'd0, 7'd0);
    send_fields(ACT_MAP, 6'd2, walk_addr(9'd5, 9'd5, 9'd5), 31'd6, FSEL_WRITABLE, 1'b0);
  endtask

  // Pool base moves: wrap of the 40-bit page number, links that shift onto
  // other tables, and present links that no longer decode.
  task automatic test_link_decode();
    set_config(40'hFF_FFFF_FFFE, 7'd1);
    send_fields(ACT_MAP, 6'd3, walk_addr(9'd9, 9'd9, 9'd9), 31'd7, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_QUERY, 6'd3, walk_addr(9'd9, 9'd9, 9'd9), 31'd0, FSEL_WRITABLE, 1'b0);
    send_fields(ACT_QUERY, 6'd0, walk_addr(9'd0, 9'd0, 9'h1FF), 31'd0, FSEL_WRITABLE,
                1'b0);
    set_config(40'h80_0000_0000, 7'd4);
    send_fields(ACT_QUERY, 6'd3, walk_addr(9'd9, 9'd9, 9'd9), 31'd0, FSEL_DIRTY, 1'b0);
    send_fields(ACT_MAP, 6'd3, walk_addr(9'd9, 9'd9, 9'd8), 31'd8, FSEL_WRITABLE, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic [39:0] base,
                                     input logic [6:0] first, input int unsigned in_gap,
                                     input int unsigned out_gap);
    int unsigned n;
    set_config(base, first);
    in_gap_max  = in_gap;
    out_gap_max = out_gap;
    hot_top     = 9'($urandom_range(0, 500));
    for (n = 0; n < count; n++) send_request(random_request());
  endtask

  // Sink stops for a long stretch while requests keep coming, so the block
  // backs up into its request channel.
  task automatic test_backpressure();
    int unsigned n;
    in_gap_max  = 0;
    out_gap_max = 1;
    hold_req    = 1'b1;
    for (n = 0; n < 40; n++) send_request(random_request());
  endtask

  // --------------------------------------------------------------------------
  // Result sink: per-result random stall, plus the long hold when asked
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned pause;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      pause = $urandom_range(0, out_gap_max);
      if (hold_req) begin
        pause    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted result
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned seq,
                                 input logic [63:0] got, input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got %h expected %h", seq, what, got, want);
  endtask

  always @(posedge clk) begin
    map_rsp_t exp_rsp;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, entry", result_seq, entry_value, 64'd0);
      end else begin
        exp_rsp = expected_q.pop_front();
        if (status !== exp_rsp.status)
          report_mismatch("status", result_seq, 64'(status), 64'(exp_rsp.status));
        if (flag_bit !== exp_rsp.flag)
          report_mismatch("flag_bit", result_seq, 64'(flag_bit), 64'(exp_rsp.flag));
        if (entry_value !== exp_rsp.entry)
          report_mismatch("entry_value", result_seq, entry_value, exp_rsp.entry);
      end
      result_seq++;
    end
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int i;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_MAP;
    root_table   = '0;
    virt_addr    = '0;
    frame_number = '0;
    flag_select  = FSEL_WRITABLE;
    flag_value   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = REG_POOL_BASE;
    pwdata       = '0;
    error_count  = 0;
    result_seq   = 0;
    idle_cycles  = 0;
    in_gap_max   = 3;
    out_gap_max  = 3;
    hold_req     = 1'b0;
    hot_top      = '0;
    for (i = 0; i < NUM_TABLES * TABLE_ENTRIES; i++) shadow_store[i] = 64'd0;
    shadow_pool_base = 40'd0;
    shadow_next_free = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers may be written during the clearing pass; requests wait on ready
    set_config(40'd0, 7'd4);
    test_directed_walks();
    test_pool_limits();
    test_link_decode();

    test_random_traffic(300, 40'd0, 7'd4, 3, 3);
    test_random_traffic(200, 40'hFF_FFFF_FFFF, 7'd4, 0, 0);
    test_random_traffic(180, {$urandom, $urandom} & 40'hFF_FFFF_FFFF, 7'd1, 3, 0);
    // small shift of the base: old links now land on neighboring tables
    test_random_traffic(150, shadow_pool_base + 40'd2, 7'd0, 0, 3);
    test_random_traffic(150, 40'h55_5555_5555, 7'd60, 2, 2);
    test_backpressure();

    drain_requests();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
